// ===== rtl/nlcc_pkg.sv =====
package nlcc_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Magnitude limit 2^63 and the positive clamp value
  localparam logic [63:0] MagCap = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_ZERO   = 4'd1,
    PH_INT    = 4'd2,
    PH_HEX0   = 4'd3,
    PH_HEX    = 4'd4,
    PH_FRAC   = 4'd5,
    PH_EXP0   = 4'd6,
    PH_EXPD   = 4'd7,
    PH_SPSKIP = 4'd8,
    PH_SPDIG  = 4'd9,
    PH_E_INT  = 4'd10,
    PH_E_HEX  = 4'd11,
    PH_E_FLT  = 4'd12,
    PH_E_BAD  = 4'd13
  } scan_phase_e;

  typedef enum logic [1:0] {
    BP_EMPTY = 2'd0,
    BP_RUN   = 2'd1,
    BP_YES   = 2'd2,
    BP_NO    = 2'd3
  } bin_phase_e;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_DEC = 2'd1,
    BASE_HEX = 2'd2
  } base_e;

  typedef enum logic [2:0] {
    KIND_DEC = 3'd0,
    KIND_HEX = 3'd1,
    KIND_BIN = 3'd2,
    KIND_FLT = 3'd3,
    KIND_BAD = 3'd4
  } kind_e;

  typedef struct packed {
    scan_phase_e scan_phase;
    logic        is_negative;
    logic [63:0] main_accum;
    logic        main_clamped;
    bin_phase_e  bin_phase;
    logic [63:0] bin_accum;
    logic        bin_clamped;
  } lex_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic        saturated;
  } result_t;

  localparam lex_state_t LexReset = '{
    scan_phase:   PH_START,
    is_negative:  1'b0,
    main_accum:   64'd0,
    main_clamped: 1'b0,
    bin_phase:    BP_EMPTY,
    bin_accum:    64'd0,
    bin_clamped:  1'b0
  };

endpackage

// ===== rtl/nlcc_if.sv =====
interface nlcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, output ch, output last_char, input ready);
  modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface nlcc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [63:0] value;
  logic               saturated;

  modport source (output valid, output kind, output value, output saturated, input ready);
  modport sink   (input valid, input kind, input value, input saturated, output ready);
endinterface

// ===== rtl/nlcc_acc.sv =====
module nlcc_acc (
  input  nlcc_pkg::base_e base_i,
  input  logic            en_i,
  input  logic [3:0]      digit_i,
  input  logic [63:0]     mag_i,
  input  logic            over_i,
  output logic [63:0]     mag_o,
  output logic            over_o
);
  import nlcc_pkg::*;

  logic [67:0] prod;
  logic [67:0] sum;

  always_comb begin
    case (base_i)
      BASE_DEC: prod = {1'b0, mag_i, 3'b000} + {3'b000, mag_i, 1'b0};
      BASE_HEX: prod = {mag_i, 4'b0000};
      BASE_BIN: prod = {3'b000, mag_i, 1'b0};
      default:  prod = 68'd0;
    endcase
    sum    = prod + {64'd0, digit_i};
    mag_o  = mag_i;
    over_o = over_i;
    // Flag and hold once the magnitude would pass 2^63
    if (en_i && !over_i) begin
      if (sum > {4'd0, MagCap}) begin
        over_o = 1'b1;
      end else begin
        mag_o = sum[63:0];
      end
    end
  end

endmodule

// ===== rtl/nlcc_scan.sv =====
module nlcc_scan (
  input  nlcc_pkg::lex_state_t state_i,
  input  logic [7:0]           ch_i,
  input  logic                 last_i,
  output nlcc_pkg::lex_state_t state_o,
  output nlcc_pkg::result_t    result_o
);
  import nlcc_pkg::*;

  logic        is_dec;
  logic        is_term;
  logic        is_ws;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic        main_en;
  base_e       main_base;
  logic [3:0]  main_digit;
  logic        bin_en;
  scan_phase_e phase_d;
  logic        neg_d;
  bin_phase_e  bin_d;
  logic [63:0] main_acc_d;
  logic        main_clamp_d;
  logic [63:0] bin_acc_d;
  logic        bin_clamp_d;
  scan_phase_e phase_end;
  bin_phase_e  bin_end;
  lex_state_t  fed;

  // End of string applied after the final character
  function automatic scan_phase_e end_scan(input scan_phase_e ph);
    scan_phase_e r;
    case (ph)
      PH_START, PH_ZERO, PH_INT, PH_SPSKIP, PH_SPDIG: r = PH_E_INT;
      PH_HEX0:                                      r = PH_E_BAD;
      PH_HEX:                                       r = PH_E_HEX;
      PH_FRAC, PH_EXP0, PH_EXPD:                    r = PH_E_FLT;
      default:                                      r = ph;
    endcase
    return r;
  endfunction

  always_comb begin
    is_dec  = ch_i inside {[CH_0:CH_9]};
    is_term = (ch_i == CH_SP) || (ch_i == CH_NUL);
    is_ws   = (ch_i == CH_SP) || (ch_i inside {[CH_TAB:CH_CR]});
    is_hex  = is_dec || (ch_i inside {[CH_LA:CH_LF]}) || (ch_i inside {[CH_UA:CH_UF]});
    hex_val = is_dec ? ch_i[3:0] : 4'(ch_i[3:0] + 4'd9);
  end

  // Main scanner
  always_comb begin
    phase_d    = state_i.scan_phase;
    neg_d      = state_i.is_negative;
    main_en    = 1'b0;
    main_base  = BASE_DEC;
    main_digit = ch_i[3:0];
    case (state_i.scan_phase)
      PH_START: begin
        if (ch_i == CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_INT;
        end else if (ch_i == CH_0) begin
          phase_d = PH_ZERO;
        end else if (is_dec) begin
          main_en = 1'b1;
          phase_d = PH_INT;
        end else if (ch_i == CH_SP) begin
          phase_d = PH_SPSKIP;
        end else if (ch_i == CH_NUL) begin
          phase_d = PH_E_INT;
        end else if (ch_i == CH_DOT) begin
          phase_d = PH_FRAC;
        end else if (ch_i == CH_LE) begin
          phase_d = PH_EXP0;
        end else begin
          phase_d = PH_E_BAD;
        end
      end
      PH_ZERO, PH_INT: begin
        if (state_i.scan_phase == PH_ZERO && (ch_i == CH_LX || ch_i == CH_UX)) begin
          phase_d = PH_HEX0;
        end else if (is_dec) begin
          main_en = 1'b1;
          phase_d = PH_INT;
        end else if (ch_i == CH_DOT) begin
          phase_d = PH_FRAC;
        end else if (ch_i == CH_LE) begin
          phase_d = PH_EXP0;
        end else if (is_term) begin
          phase_d = PH_E_INT;
        end else begin
          phase_d = PH_E_BAD;
        end
      end
      PH_HEX0, PH_HEX: begin
        main_base  = BASE_HEX;
        main_digit = hex_val;
        if (is_hex) begin
          main_en = 1'b1;
          phase_d = PH_HEX;
        end else if (state_i.scan_phase == PH_HEX && is_term) begin
          phase_d = PH_E_HEX;
        end else begin
          phase_d = PH_E_BAD;
        end
      end
      PH_FRAC: begin
        if (is_dec) begin
          phase_d = PH_FRAC;
        end else if (ch_i == CH_LE) begin
          phase_d = PH_EXP0;
        end else begin
          phase_d = is_term ? PH_E_FLT : PH_E_BAD;
        end
      end
      PH_EXP0: begin
        if (ch_i == CH_PLUS || ch_i == CH_MINUS || is_dec) begin
          phase_d = PH_EXPD;
        end else begin
          phase_d = is_term ? PH_E_FLT : PH_E_BAD;
        end
      end
      PH_EXPD: begin
        if (!is_dec) begin
          phase_d = is_term ? PH_E_FLT : PH_E_BAD;
        end
      end
      PH_SPSKIP: begin
        if (is_ws) begin
          phase_d = PH_SPSKIP;
        end else if (ch_i == CH_PLUS) begin
          phase_d = PH_SPDIG;
        end else if (ch_i == CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_SPDIG;
        end else if (is_dec) begin
          main_en = 1'b1;
          phase_d = PH_SPDIG;
        end else begin
          phase_d = PH_E_INT;
        end
      end
      PH_SPDIG: begin
        if (is_dec) begin
          main_en = 1'b1;
        end else begin
          phase_d = PH_E_INT;
        end
      end
      default: begin
        phase_d = state_i.scan_phase;
      end
    endcase
  end

  // Binary run tracker
  always_comb begin
    bin_d  = state_i.bin_phase;
    bin_en = 1'b0;
    if (state_i.bin_phase == BP_EMPTY || state_i.bin_phase == BP_RUN) begin
      if (ch_i == CH_0 || ch_i == CH_1) begin
        bin_en = 1'b1;
        bin_d  = BP_RUN;
      end else if (state_i.bin_phase == BP_RUN && (ch_i == CH_LB || ch_i == CH_UB)) begin
        bin_d = BP_YES;
      end else begin
        bin_d = BP_NO;
      end
    end
  end

  nlcc_acc u_main_acc (
    .base_i  (main_base),
    .en_i    (main_en),
    .digit_i (main_digit),
    .mag_i   (state_i.main_accum),
    .over_i  (state_i.main_clamped),
    .mag_o   (main_acc_d),
    .over_o  (main_clamp_d)
  );

  nlcc_acc u_bin_acc (
    .base_i  (BASE_BIN),
    .en_i    (bin_en),
    .digit_i ({3'b000, ch_i[0]}),
    .mag_i   (state_i.bin_accum),
    .over_i  (state_i.bin_clamped),
    .mag_o   (bin_acc_d),
    .over_o  (bin_clamp_d)
  );

  always_comb begin
    fed.scan_phase   = phase_d;
    fed.is_negative  = neg_d;
    fed.main_accum   = main_acc_d;
    fed.main_clamped = main_clamp_d;
    fed.bin_phase    = bin_d;
    fed.bin_accum    = bin_acc_d;
    fed.bin_clamped  = bin_clamp_d;

    phase_end = end_scan(phase_d);
    bin_end   = (bin_d == BP_EMPTY || bin_d == BP_RUN) ? BP_NO : bin_d;

    // Drop back to the reset state once the literal closes
    state_o = last_i ? LexReset : fed;
  end

  // Classify and clamp
  always_comb begin
    result_o.kind      = KIND_BAD;
    result_o.value     = 64'd0;
    result_o.saturated = 1'b0;
    if (phase_end == PH_E_INT || phase_end == PH_E_HEX) begin
      result_o.kind = (phase_end == PH_E_INT) ? KIND_DEC : KIND_HEX;
      if (neg_d && phase_end == PH_E_INT) begin
        if (main_clamp_d) begin
          result_o.value     = MagCap;
          result_o.saturated = 1'b1;
        end else begin
          result_o.value = ~main_acc_d + 64'd1;
        end
      end else if (main_clamp_d || main_acc_d[63]) begin
        result_o.value     = SatMax;
        result_o.saturated = 1'b1;
      end else begin
        result_o.value = main_acc_d;
      end
    end else if (phase_end == PH_E_FLT) begin
      result_o.kind = KIND_FLT;
    end else if (bin_end == BP_YES) begin
      result_o.kind = KIND_BIN;
      if (bin_clamp_d || bin_acc_d[63]) begin
        result_o.value     = SatMax;
        result_o.saturated = 1'b1;
      end else begin
        result_o.value = bin_acc_d;
      end
    end
  end

endmodule

// ===== rtl/numeric_literal_classify_convert_core.sv =====
// Numeric literal lexer: feed the characters of a literal one item per cycle on
// in_i (ch, last_char). The item with last_char set closes the literal and
// yields one result on out_o: kind (0 decimal, 1 hex, 2 binary, 3 float,
// 4 invalid), a signed 64-bit value clamped to the signed range, and a
// saturated flag. Scanning stops at the first space or NUL, except that a
// leading space starts a white-space skip; characters after that only run out
// the literal. The block sustains one character per cycle: every character
// goes through an input register, one pass of scan and accumulate logic (a
// times-10/16/2 add per digit), and the result lands in an output register
// once the closing character leaves the input register. A result waiting on
// out_o stalls input only once the next closing character reaches the scan stage.
module numeric_literal_classify_convert_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  nlcc_in_if.sink           in_i,
  nlcc_out_if.source        out_o
);
  import nlcc_pkg::*;

  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       last_q;
  lex_state_t state_q;
  lex_state_t state_d;
  result_t    res_d;
  result_t    res_q;
  logic       out_vld_q;
  logic       advance;

  // Advance the held item unless it closes a literal and the result slot is blocked
  assign advance    = in_vld_q && (!last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last_char;
    end
  end

  // Scan and accumulate in one pass
  nlcc_scan u_scan (
    .state_i  (state_q),
    .ch_i     (ch_q),
    .last_i   (last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Literal state: hold until the held item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LexReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.kind      = res_q.kind;
  assign out_o.value     = $signed(res_q.value);
  assign out_o.saturated = res_q.saturated;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import nlcc_pkg::*;

  localparam int unsigned HalfPeriod   = 10;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned IdlePct      = 38;
  localparam int unsigned NumDirRows   = 9;
  localparam int unsigned DirChars     = 25;
  localparam int unsigned TotalChars   = DirChars + 1250;
  // Character counts that place the no-idle stretch, the output hold-off and the
  // mid-run drain inside the random part.
  localparam int unsigned QuietFrom    = DirChars + 350;
  localparam int unsigned QuietTo      = DirChars + 800;
  localparam int unsigned HoldAt       = DirChars + 450;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned PauseAt      = DirChars + 950;
  // Result lands once the closing character leaves the input register; leave ample slack.
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned NumLimitLits = 8;

  // Directed row: characters right-aligned in txt, first character highest.
  typedef struct {
    logic [63:0] txt;
    int unsigned len;
    bit          typed;
    result_t     res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nlcc_in_if  char_if ();
  nlcc_out_if res_if ();

  numeric_literal_classify_convert_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (res_if)
  );

  lex_state_t  lex;                 // scanner state, advanced per accepted item
  result_t     literal_results[$];  // one entry per closed literal, oldest first
  result_t     oldest;
  logic [7:0]  lit_chars[$];        // characters of the literal being sent
  dir_row_t    dir_rows [NumDirRows];
  int unsigned chars_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  logic        quiet_win   = 1'b0;
  logic        rx_hold     = 1'b0;
  bit          paused_once = 1'b0;

  string hex_set = "0123456789abcdefABCDEF";

  // Values at and just past the signed 64-bit boundaries.
  string limit_lits [NumLimitLits] = '{
    "9223372036854775807", "9223372036854775808", "-9223372036854775808",
    "-9223372036854775809", "18446744073709551616", "0x7fffffffffffffff",
    "0x8000000000000000", "0XFFFFFFFFFFFFFFFFF"
  };

  always #(HalfPeriod) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Literal scanner prediction
  // ---------------------------------------------------------------------------

  function automatic bit dec_char(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_term(input logic [7:0] c);
    return c == CH_SP || c == CH_NUL;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (dec_char(c)) return c - CH_0;
    if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
    if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
    return -1;
  endfunction

  // Append one digit to a magnitude; once it would pass 2^63, freeze it and
  // flag the clamp. Returns {clamped, magnitude}.
  function automatic logic [64:0] grow(input logic over, input logic [63:0] mag,
                                       input logic [63:0] base, input logic [63:0] d);
    if (over || mag > (MagCap - d) / base) return {1'b1, mag};
    return {1'b0, mag * base + d};
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    int h;
    h = hex_digit(c);
    case (lex.scan_phase)
      PH_START: begin
        if (c == CH_MINUS) begin
          lex.is_negative = 1'b1;
          lex.scan_phase  = PH_INT;
        end else if (c == CH_0) begin
          lex.scan_phase = PH_ZERO;
        end else if (dec_char(c)) begin
          {lex.main_clamped, lex.main_accum} =
            grow(lex.main_clamped, lex.main_accum, 64'd10, 64'(c - CH_0));
          lex.scan_phase = PH_INT;
        end else if (c == CH_SP) begin
          lex.scan_phase = PH_SPSKIP;
        end else if (c == CH_NUL) begin
          lex.scan_phase = PH_E_INT;
        end else if (c == CH_DOT) begin
          lex.scan_phase = PH_FRAC;
        end else if (c == CH_LE) begin
          lex.scan_phase = PH_EXP0;
        end else begin
          lex.scan_phase = PH_E_BAD;
        end
      end
      PH_ZERO, PH_INT: begin
        // Only a lone leading zero may turn into a hex prefix.
        if (lex.scan_phase == PH_ZERO && (c == CH_LX || c == CH_UX)) begin
          lex.scan_phase = PH_HEX0;
        end else if (dec_char(c)) begin
          {lex.main_clamped, lex.main_accum} =
            grow(lex.main_clamped, lex.main_accum, 64'd10, 64'(c - CH_0));
          lex.scan_phase = PH_INT;
        end else if (c == CH_DOT) begin
          lex.scan_phase = PH_FRAC;
        end else if (c == CH_LE) begin
          lex.scan_phase = PH_EXP0;
        end else begin
          lex.scan_phase = is_term(c) ? PH_E_INT : PH_E_BAD;
        end
      end
      PH_HEX0, PH_HEX: begin
        if (h >= 0) begin
          {lex.main_clamped, lex.main_accum} =
            grow(lex.main_clamped, lex.main_accum, 64'd16, 64'(h));
          lex.scan_phase = PH_HEX;
        end else if (lex.scan_phase == PH_HEX && is_term(c)) begin
          lex.scan_phase = PH_E_HEX;
        end else begin
          lex.scan_phase = PH_E_BAD;
        end
      end
      PH_FRAC: begin
        if (c == CH_LE) lex.scan_phase = PH_EXP0;
        else if (!dec_char(c)) lex.scan_phase = is_term(c) ? PH_E_FLT : PH_E_BAD;
      end
      PH_EXP0: begin
        if (c == CH_PLUS || c == CH_MINUS || dec_char(c)) lex.scan_phase = PH_EXPD;
        else lex.scan_phase = is_term(c) ? PH_E_FLT : PH_E_BAD;
      end
      PH_EXPD: begin
        if (!dec_char(c)) lex.scan_phase = is_term(c) ? PH_E_FLT : PH_E_BAD;
      end
      PH_SPSKIP: begin
        // Skip white space, then take a sign or the first digit.
        if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
        end else if (c == CH_PLUS) begin
          lex.scan_phase = PH_SPDIG;
        end else if (c == CH_MINUS) begin
          lex.is_negative = 1'b1;
          lex.scan_phase  = PH_SPDIG;
        end else if (dec_char(c)) begin
          {lex.main_clamped, lex.main_accum} =
            grow(lex.main_clamped, lex.main_accum, 64'd10, 64'(c - CH_0));
          lex.scan_phase = PH_SPDIG;
        end else begin
          lex.scan_phase = PH_E_INT;
        end
      end
      PH_SPDIG: begin
        if (dec_char(c)) begin
          {lex.main_clamped, lex.main_accum} =
            grow(lex.main_clamped, lex.main_accum, 64'd10, 64'(c - CH_0));
        end else begin
          lex.scan_phase = PH_E_INT;
        end
      end
      default: begin
      end
    endcase

    // The binary run is tracked alongside, until a 'b' or a stray character.
    if (lex.bin_phase == BP_EMPTY || lex.bin_phase == BP_RUN) begin
      if (c == CH_0 || c == CH_1) begin
        {lex.bin_clamped, lex.bin_accum} =
          grow(lex.bin_clamped, lex.bin_accum, 64'd2, 64'(c - CH_0));
        lex.bin_phase = BP_RUN;
      end else if (lex.bin_phase == BP_RUN && (c == CH_LB || c == CH_UB)) begin
        lex.bin_phase = BP_YES;
      end else begin
        lex.bin_phase = BP_NO;
      end
    end
  endfunction

  // Advance the scanner by one accepted item; on the closing item, run out the
  // literal with a NUL, classify it and return to the idle state.
  function automatic void lex_char(input logic [7:0] c, input logic last,
                                   output bit got, output result_t res);
    scan_char(c);
    got = last;
    res = '0;
    if (!last) return;
    scan_char(CH_NUL);
    if (lex.scan_phase == PH_E_INT || lex.scan_phase == PH_E_HEX) begin
      res.kind = (lex.scan_phase == PH_E_INT) ? KIND_DEC : KIND_HEX;
      if (lex.is_negative && res.kind == KIND_DEC) begin
        // Minus 2^63 is exact; only a clamped magnitude saturates.
        if (lex.main_clamped) begin
          res.value     = MagCap;
          res.saturated = 1'b1;
        end else begin
          res.value = ~lex.main_accum + 64'd1;
        end
      end else if (lex.main_clamped || lex.main_accum >= MagCap) begin
        res.value     = SatMax;
        res.saturated = 1'b1;
      end else begin
        res.value = lex.main_accum;
      end
    end else if (lex.scan_phase == PH_E_FLT) begin
      res.kind = KIND_FLT;
    end else if (lex.bin_phase == BP_YES) begin
      res.kind = KIND_BIN;
      if (lex.bin_clamped || lex.bin_accum >= MagCap) begin
        res.value     = SatMax;
        res.saturated = 1'b1;
      end else begin
        res.value = lex.bin_accum;
      end
    end else begin
      res.kind = KIND_BAD;
    end
    lex = LexReset;
  endfunction

  // ---------------------------------------------------------------------------
  // Random literal construction
  // ---------------------------------------------------------------------------

  // Append one character to the literal being built.
  function automatic void add_char(input logic [7:0] c);
    lit_chars.insert(lit_chars.size(), c);
  endfunction

  // Mostly short runs, now and then long enough to clamp.
  function automatic int unsigned run_len(input int unsigned short_max,
                                          input int unsigned long_max);
    if ($urandom_range(9) == 0) return $urandom_range(short_max + 1, long_max);
    return $urandom_range(1, short_max);
  endfunction

  function automatic void add_digits(input int unsigned n, input bit hex);
    repeat (n) begin
      if (hex) add_char(hex_set[$urandom_range(hex_set.len() - 1)]);
      else add_char(CH_0 + 8'($urandom_range(9)));
    end
  endfunction

  function automatic void add_noise(input int unsigned n);
    repeat (n) add_char(8'($urandom_range(255)));
  endfunction

  // Short well-formed body of any class, for the terminated and broken cases.
  function automatic void add_short_body();
    case ($urandom_range(3))
      0: add_digits($urandom_range(1, 4), 1'b0);
      1: begin
        add_char(CH_0);
        add_char(CH_LX);
        add_digits($urandom_range(1, 3), 1'b1);
      end
      2: begin
        add_digits($urandom_range(1, 2), 1'b0);
        add_char(CH_DOT);
        add_digits($urandom_range(2), 1'b0);
      end
      default: begin
        repeat ($urandom_range(1, 4)) add_char($urandom_range(1) ? CH_1 : CH_0);
        add_char(CH_LB);
      end
    endcase
  endfunction

  function automatic void build_literal();
    int unsigned pick;
    int unsigned n;
    string       s;
    lit_chars.delete();
    pick = $urandom_range(99);
    if (pick < 18) begin
      // Decimal, optionally negative.
      if ($urandom_range(2) == 0) add_char(CH_MINUS);
      add_digits(run_len(6, 22), 1'b0);
    end else if (pick < 30) begin
      add_char(CH_0);
      add_char($urandom_range(1) ? CH_LX : CH_UX);
      add_digits(run_len(5, 18), 1'b1);
    end else if (pick < 42) begin
      // Binary run, long ones led by a one so the longest reach the clamp.
      n = run_len(8, 66);
      for (int i = 0; i < n; i++) begin
        if (i == 0 && n > 8) add_char(CH_1);
        else add_char($urandom_range(1) ? CH_1 : CH_0);
      end
      add_char($urandom_range(1) ? CH_LB : CH_UB);
      add_noise($urandom_range(3));
    end else if (pick < 52) begin
      // Float: every part optional.
      add_digits($urandom_range(3), 1'b0);
      if ($urandom_range(3) != 0) add_char(CH_DOT);
      add_digits($urandom_range(3), 1'b0);
      if ($urandom_range(1)) begin
        add_char(CH_LE);
        n = $urandom_range(2);
        if (n == 1) add_char(CH_PLUS);
        else if (n == 2) add_char(CH_MINUS);
        add_digits($urandom_range(2), 1'b0);
      end
      if (lit_chars.size() == 0) add_char(CH_DOT);
    end else if (pick < 60) begin
      // Leading space: white space, sign, digits, then anything.
      add_char(CH_SP);
      repeat ($urandom_range(2))
        add_char($urandom_range(1) ? CH_SP : 8'($urandom_range(CH_TAB, CH_CR)));
      n = $urandom_range(2);
      if (n == 1) add_char(CH_PLUS);
      else if (n == 2) add_char(CH_MINUS);
      if ($urandom_range(5) != 0) add_digits(run_len(5, 21), 1'b0);
      add_noise($urandom_range(2));
    end else if (pick < 70) begin
      n = $urandom_range(NumLimitLits);
      if (n == NumLimitLits) begin
        // Largest binary value that fits.
        repeat (63) add_char(CH_1);
        add_char(CH_LB);
      end else begin
        s = limit_lits[n];
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
      end
    end else if (pick < 80) begin
      // Terminator followed by junk that must not change the class.
      add_short_body();
      add_char($urandom_range(1) ? CH_SP : CH_NUL);
      add_noise($urandom_range(1, 3));
    end else if (pick < 90) begin
      // Broken: one character of a good body replaced at random.
      add_short_body();
      lit_chars[$urandom_range(lit_chars.size() - 1)] = 8'($urandom_range(255));
    end else begin
      add_noise($urandom_range(1, 5));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until taken, then predict and maybe idle.
  task automatic push_char(input logic [7:0] c, input logic last, input bit use_typed,
                           input result_t typed);
    bit      got;
    result_t lexed;
    char_if.valid     <= 1'b1;
    char_if.ch        <= c;
    char_if.last_char <= last;
    do @(posedge clk_i); while (!char_if.ready);
    lex_char(c, last, got, lexed);
    if (got) literal_results.insert(literal_results.size(), use_typed ? typed : lexed);
    chars_sent++;
    if (!quiet_win && $urandom_range(99) < IdlePct) begin
      // Idle with junk on the bus; stay idle with the same odds each cycle.
      char_if.valid     <= 1'b0;
      char_if.ch        <= 8'($urandom_range(255));
      char_if.last_char <= 1'($urandom_range(1));
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_results();
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (literal_results.size() != 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    char_if.valid     <= 1'b0;
    char_if.ch        <= CH_NUL;
    char_if.last_char <= 1'b0;
    lex = LexReset;

    // Directed literals: typed results for the obvious ones, the scanner for
    // the rest. Covers the empty literal, a bare sign, leading white space,
    // hex, binary with a tail, float, an all-ones byte, text after a NUL and
    // a hex prefix with no digits.
    dir_rows = '{
      '{{CH_NUL},               1, 1'b1, '{KIND_DEC, 64'd0, 1'b0}},
      '{"-",                    1, 1'b1, '{KIND_DEC, 64'd0, 1'b0}},
      '{{" ", CH_TAB, "-7"},    4, 1'b0, '0},
      '{"0x1F",                 4, 1'b0, '0},
      '{"10b?",                 4, 1'b0, '0},
      '{".5e-3",                5, 1'b0, '0},
      '{64'hFF,                 1, 1'b1, '{KIND_BAD, 64'd0, 1'b0}},
      '{{"7", CH_NUL, "q"},     3, 1'b0, '0},
      '{"0x",                   2, 1'b1, '{KIND_BAD, 64'd0, 1'b0}}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].len; i++) begin
        push_char(dir_rows[r].txt[8 * (dir_rows[r].len - 1 - i) +: 8],
                  i == dir_rows[r].len - 1, dir_rows[r].typed, dir_rows[r].res);
      end
    end
    drain_results();

    // Random literals; a window in the middle runs with no idling on either
    // side, and the output hold-off lands inside it.
    while (chars_sent < TotalChars) begin
      quiet_win <= (chars_sent >= QuietFrom && chars_sent < QuietTo);
      if (!paused_once && chars_sent >= PauseAt) begin
        paused_once = 1'b1;
        drain_results();
      end
      build_literal();
      foreach (lit_chars[i]) push_char(lit_chars[i], i == lit_chars.size() - 1, 1'b0, '0);
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Hold ready low for a long stretch while items keep coming, so the block
  // fills up and stalls its input.
  initial begin
    while (chars_sent < HoldAt) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Compare each taken result with the oldest prediction.
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      if (literal_results.size() == 0) begin
        $display("%0t: expected no result, got kind=%0d value=%0d saturated=%0b",
                 $time, res_if.kind, res_if.value, res_if.saturated);
        mismatches++;
      end else begin
        oldest = literal_results.pop_front();
        if (res_if.kind !== oldest.kind || res_if.value !== oldest.value ||
            res_if.saturated !== oldest.saturated) begin
          $display("%0t: expected kind=%0d value=%0d saturated=%0b, got kind=%0d value=%0d saturated=%0b",
                   $time, oldest.kind, $signed(oldest.value), oldest.saturated,
                   res_if.kind, res_if.value, res_if.saturated);
          mismatches++;
        end
      end
    end
    res_if.ready <= !rx_hold && (quiet_win || $urandom_range(99) >= IdlePct);
  end

  // Bound the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
